[hdl/mgsp_pkg.sv]
// ----------------------------------------------------------------------------
// mgsp_pkg
// Types and constants shared by the mesh geometry stream parser modules.
// ----------------------------------------------------------------------------
package mgsp_pkg;

  localparam logic [31:0] MAGIC_RESET = 32'h4247_3031;

  // option flag bits
  localparam int unsigned OPT_TEXCOORD = 0;
  localparam int unsigned OPT_NORMAL   = 1;
  localparam int unsigned OPT_EXTRA    = 2;
  localparam int unsigned OPT_TAG      = 3;
  localparam int unsigned OPT_SKIN_IDX = 4;
  localparam int unsigned OPT_SKIN_WGT = 5;

  // section codes
  localparam logic [4:0] SEC_HEADER    = 5'd0;
  localparam logic [4:0] SEC_POSITION  = 5'd1;
  localparam logic [4:0] SEC_NORMAL    = 5'd2;
  localparam logic [4:0] SEC_TEXCOORD  = 5'd3;
  localparam logic [4:0] SEC_INDEX     = 5'd4;
  localparam logic [4:0] SEC_SKIN_CNT  = 5'd5;
  localparam logic [4:0] SEC_SKIN_GRP  = 5'd6;
  localparam logic [4:0] SEC_SKIN_MAP  = 5'd7;
  localparam logic [4:0] SEC_WGT_CNT   = 5'd8;
  localparam logic [4:0] SEC_WGT_DATA  = 5'd9;
  localparam logic [4:0] SEC_WGT_MAP   = 5'd10;
  localparam logic [4:0] SEC_EXTRA_LEN = 5'd11;
  localparam logic [4:0] SEC_EXTRA_DAT = 5'd12;
  localparam logic [4:0] SEC_EXTRA_MAP = 5'd13;
  localparam logic [4:0] SEC_TAG_WORD  = 5'd14;
  localparam logic [4:0] SEC_TAG_LEN   = 5'd15;
  localparam logic [4:0] SEC_TAG_BYTES = 5'd16;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_EARLY_END = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  section;
    logic [31:0] element_index;
    logic [1:0]  component;
    logic [31:0] field_value;
    logic [1:0]  status;
    logic        file_done;
  } out_word_t;

endpackage

[hdl/mgsp_queue.sv]
// ----------------------------------------------------------------------------
// mgsp_queue
// Two-entry input queue; decouples byte intake from the parser core.
// ----------------------------------------------------------------------------
module mgsp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mgsp_pkg::in_word_t in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output mgsp_pkg::in_word_t q_data
);

  mgsp_pkg::in_word_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_data   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // store incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill != 2'd0))
    else $error("push lost");

endmodule

[hdl/mgsp_core.sv]
// ----------------------------------------------------------------------------
// mgsp_core
// Parser back end: word assembly, header decode, section walk, output register.
// ----------------------------------------------------------------------------
module mgsp_core #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [31:0]         magic_word,
  input  logic                q_valid,
  output logic                q_ready,
  input  mgsp_pkg::in_word_t  q_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mgsp_pkg::out_word_t out_data
);

  typedef struct packed {
    logic       done;
    logic [4:0] sec;
  } enter_t;

  // parser state
  logic [4:0]            phase;
  logic [1:0]            byte_pos;
  logic [23:0]           word_asm;
  logic [COUNT_BITS-1:0] vtx_total;
  logic [COUNT_BITS-1:0] idx_total;
  logic [5:0]            opt_flags;
  logic [COUNT_BITS-1:0] elem_cnt;
  logic [1:0]            comp_cnt;
  logic [COUNT_BITS-1:0] blk_len;
  logic                  finished;

  logic [4:0]            phase_next;
  logic [1:0]            byte_pos_next;
  logic [23:0]           word_asm_next;
  logic [COUNT_BITS-1:0] vtx_total_next;
  logic [COUNT_BITS-1:0] idx_total_next;
  logic [5:0]            opt_flags_next;
  logic [COUNT_BITS-1:0] elem_cnt_next;
  logic [1:0]            comp_cnt_next;
  logic [COUNT_BITS-1:0] blk_len_next;
  logic                  finished_next;

  logic                  take;
  logic                  res_valid;
  mgsp_pkg::out_word_t   res;

  // section has elements, given its flags and counts
  function automatic logic sec_live(input logic [4:0] s, input logic [5:0] f,
                                    input logic vz, input logic iz,
                                    input logic bz);
    logic r;
    begin
      case (s)
        mgsp_pkg::SEC_POSITION:  r = !vz;
        mgsp_pkg::SEC_NORMAL:    r = f[mgsp_pkg::OPT_NORMAL] && !vz;
        mgsp_pkg::SEC_TEXCOORD:  r = f[mgsp_pkg::OPT_TEXCOORD] && !vz;
        mgsp_pkg::SEC_INDEX:     r = !iz;
        mgsp_pkg::SEC_SKIN_CNT:  r = f[mgsp_pkg::OPT_SKIN_IDX];
        mgsp_pkg::SEC_SKIN_GRP:  r = f[mgsp_pkg::OPT_SKIN_IDX] && !bz;
        mgsp_pkg::SEC_SKIN_MAP:  r = f[mgsp_pkg::OPT_SKIN_IDX] && !iz;
        mgsp_pkg::SEC_WGT_CNT:   r = f[mgsp_pkg::OPT_SKIN_WGT];
        mgsp_pkg::SEC_WGT_DATA:  r = f[mgsp_pkg::OPT_SKIN_WGT] && !bz;
        mgsp_pkg::SEC_WGT_MAP:   r = f[mgsp_pkg::OPT_SKIN_WGT] && !iz;
        mgsp_pkg::SEC_EXTRA_LEN: r = f[mgsp_pkg::OPT_EXTRA];
        mgsp_pkg::SEC_EXTRA_DAT: r = f[mgsp_pkg::OPT_EXTRA] && !bz;
        mgsp_pkg::SEC_EXTRA_MAP: r = f[mgsp_pkg::OPT_EXTRA] && !vz;
        mgsp_pkg::SEC_TAG_WORD:  r = f[mgsp_pkg::OPT_TAG];
        mgsp_pkg::SEC_TAG_LEN:   r = f[mgsp_pkg::OPT_TAG];
        mgsp_pkg::SEC_TAG_BYTES: r = f[mgsp_pkg::OPT_TAG] && !bz;
        default:                 r = 1'b0;
      endcase
      return r;
    end
  endfunction

  // first live section at or after start; done when none is left
  function automatic enter_t find_sec(input logic [4:0] start, input logic [5:0] f,
                                      input logic vz, input logic iz,
                                      input logic bz);
    enter_t r;
    begin
      r.done = 1'b1;
      r.sec  = mgsp_pkg::SEC_HEADER;
      for (int k = 16; k >= 1; k--) begin
        if (5'(k) >= start && sec_live(5'(k), f, vz, iz, bz)) begin
          r.done = 1'b0;
          r.sec  = 5'(k);
        end
      end
      return r;
    end
  endfunction

  function automatic logic [1:0] comps_of(input logic [4:0] s);
    logic [1:0] r;
    begin
      case (s)
        mgsp_pkg::SEC_POSITION, mgsp_pkg::SEC_NORMAL, mgsp_pkg::SEC_WGT_DATA: r = 2'd3;
        mgsp_pkg::SEC_TEXCOORD: r = 2'd2;
        default:                r = 2'd1;
      endcase
      return r;
    end
  endfunction

  assign take    = q_valid && q_ready;
  assign q_ready = !out_valid || out_ready;

  // step one byte through the parser
  always_comb begin
    logic [4:0]            c_phase;
    logic [1:0]            c_bp;
    logic [23:0]           c_wa;
    logic [COUNT_BITS-1:0] c_vt;
    logic [COUNT_BITS-1:0] c_it;
    logic [5:0]            c_fl;
    logic [COUNT_BITS-1:0] c_ec;
    logic [1:0]            c_cc;
    logic [COUNT_BITS-1:0] c_bl;
    logic                  c_fin;
    logic                  payload;
    logic                  have;
    logic                  last;
    logic                  done;
    logic [31:0]           val;
    logic [COUNT_BITS-1:0] ec_inc;
    logic [1:0]            cc_inc;
    logic [COUNT_BITS-1:0] elems;
    logic [COUNT_BITS-1:0] bl_new;
    enter_t                ent;

    // restart on first byte
    if (q_data.first_byte) begin
      c_phase = mgsp_pkg::SEC_HEADER; c_bp = '0; c_wa = '0; c_vt = '0; c_it = '0;
      c_fl = '0; c_ec = '0; c_cc = '0; c_bl = '0; c_fin = 1'b0;
    end else begin
      c_phase = phase; c_bp = byte_pos; c_wa = word_asm; c_vt = vtx_total;
      c_it = idx_total; c_fl = opt_flags; c_ec = elem_cnt; c_cc = comp_cnt;
      c_bl = blk_len; c_fin = finished;
    end

    phase_next = c_phase; byte_pos_next = c_bp; word_asm_next = c_wa;
    vtx_total_next = c_vt; idx_total_next = c_it; opt_flags_next = c_fl;
    elem_cnt_next = c_ec; comp_cnt_next = c_cc; blk_len_next = c_bl;
    finished_next = c_fin;
    res_valid = 1'b0;
    res = '0;
    last = q_data.last_byte;
    done = 1'b0;
    ent = '0;
    elems = '0;
    bl_new = c_bl;
    ec_inc = c_ec + COUNT_BITS'(1);
    cc_inc = c_cc + 2'd1;

    payload = (c_phase == mgsp_pkg::SEC_EXTRA_DAT) || (c_phase == mgsp_pkg::SEC_TAG_BYTES);
    have = payload || (c_bp == 2'd3);
    val = payload ? {24'd0, q_data.data_byte} : {q_data.data_byte, c_wa};

    if (!c_fin) begin
      // gather bytes into a word
      if (!payload) begin
        if (c_bp == 2'd3) begin
          byte_pos_next = 2'd0;
          word_asm_next = '0;
        end else begin
          byte_pos_next = c_bp + 2'd1;
          case (c_bp)
            2'd0:    word_asm_next[7:0]   = q_data.data_byte;
            2'd1:    word_asm_next[15:8]  = q_data.data_byte;
            default: word_asm_next[23:16] = q_data.data_byte;
          endcase
        end
      end

      if (!have) begin
        // early end inside a word
        if (last) begin
          res_valid = 1'b1;
          res.status = mgsp_pkg::ST_EARLY_END;
          finished_next = 1'b1;
          if (c_phase == mgsp_pkg::SEC_HEADER) begin
            res.section = mgsp_pkg::SEC_HEADER;
            res.component = (c_ec != '0) ? 2'(c_ec - COUNT_BITS'(1)) : 2'd0;
          end else begin
            res.section = c_phase;
            res.element_index = 32'(c_ec);
            res.component = c_cc;
          end
        end
      end else if (c_phase == mgsp_pkg::SEC_HEADER && c_ec == '0) begin
        // magic check
        if (val != magic_word) begin
          res_valid = 1'b1;
          res.field_value = val;
          res.status = mgsp_pkg::ST_BAD_MAGIC;
          finished_next = 1'b1;
        end else begin
          elem_cnt_next = COUNT_BITS'(1);
          if (last) begin
            res_valid = 1'b1;
            res.status = mgsp_pkg::ST_EARLY_END;
            finished_next = 1'b1;
          end
        end
      end else begin
        res_valid = 1'b1;
        res.field_value = val;
        if (c_phase == mgsp_pkg::SEC_HEADER) begin
          // header counts and options
          res.section = mgsp_pkg::SEC_HEADER;
          res.component = 2'(c_ec - COUNT_BITS'(1));
          if (c_ec == COUNT_BITS'(1)) begin
            vtx_total_next = val[COUNT_BITS-1:0];
            elem_cnt_next = ec_inc;
          end else if (c_ec == COUNT_BITS'(2)) begin
            idx_total_next = val[COUNT_BITS-1:0];
            elem_cnt_next = ec_inc;
          end else begin
            opt_flags_next = val[5:0];
            ent = find_sec(mgsp_pkg::SEC_POSITION, val[5:0], c_vt == '0, c_it == '0,
                           c_bl == '0);
            done = ent.done;
          end
        end else begin
          // section field
          res.section = c_phase;
          res.element_index = 32'(c_ec);
          res.component = c_cc;
          comp_cnt_next = cc_inc;
          case (c_phase)
            mgsp_pkg::SEC_POSITION, mgsp_pkg::SEC_NORMAL, mgsp_pkg::SEC_TEXCOORD,
            mgsp_pkg::SEC_EXTRA_MAP: elems = c_vt;
            mgsp_pkg::SEC_INDEX, mgsp_pkg::SEC_SKIN_MAP, mgsp_pkg::SEC_WGT_MAP:
              elems = c_it;
            mgsp_pkg::SEC_SKIN_GRP, mgsp_pkg::SEC_WGT_DATA, mgsp_pkg::SEC_EXTRA_DAT,
            mgsp_pkg::SEC_TAG_BYTES: elems = c_bl;
            default: elems = COUNT_BITS'(1);
          endcase
          if (cc_inc == comps_of(c_phase)) begin
            comp_cnt_next = 2'd0;
            elem_cnt_next = ec_inc;
            if (ec_inc == elems) begin
              if (c_phase == mgsp_pkg::SEC_SKIN_CNT || c_phase == mgsp_pkg::SEC_WGT_CNT ||
                  c_phase == mgsp_pkg::SEC_EXTRA_LEN || c_phase == mgsp_pkg::SEC_TAG_LEN) begin
                bl_new = val[COUNT_BITS-1:0];
              end
              blk_len_next = bl_new;
              ent = find_sec(c_phase + 5'd1, c_fl, c_vt == '0, c_it == '0, bl_new == '0);
              done = ent.done;
            end
          end
        end
        // leave for the next section or finish
        if ((c_phase == mgsp_pkg::SEC_HEADER && c_ec == COUNT_BITS'(3)) ||
            (c_phase != mgsp_pkg::SEC_HEADER && cc_inc == comps_of(c_phase) &&
             ec_inc == elems)) begin
          elem_cnt_next = '0;
          comp_cnt_next = 2'd0;
          phase_next = ent.sec;
          if (ent.done) finished_next = 1'b1;
        end
        if (!done && last) begin
          res.status = mgsp_pkg::ST_EARLY_END;
          finished_next = 1'b1;
        end else begin
          res.status = mgsp_pkg::ST_OK;
          res.file_done = done;
        end
      end
    end
  end

  // hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= mgsp_pkg::SEC_HEADER;
      byte_pos  <= '0;
      word_asm  <= '0;
      vtx_total <= '0;
      idx_total <= '0;
      opt_flags <= '0;
      elem_cnt  <= '0;
      comp_cnt  <= '0;
      blk_len   <= '0;
      finished  <= 1'b0;
    end else if (take) begin
      phase     <= phase_next;
      byte_pos  <= byte_pos_next;
      word_asm  <= word_asm_next;
      vtx_total <= vtx_total_next;
      idx_total <= idx_total_next;
      opt_flags <= opt_flags_next;
      elem_cnt  <= elem_cnt_next;
      comp_cnt  <= comp_cnt_next;
      blk_len   <= blk_len_next;
      finished  <= finished_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_data <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != mgsp_pkg::ST_OK) |-> !out_data.file_done)
    else $error("file_done with error status");
  assert property (@(posedge clk) disable iff (rst)
    (byte_pos != 2'd0) |->
      (phase != mgsp_pkg::SEC_EXTRA_DAT && phase != mgsp_pkg::SEC_TAG_BYTES))
    else $error("partial word in byte section");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !q_ready)
    else $error("core took a byte with a stalled result");
  assert property (@(posedge clk) disable iff (rst)
    (take && !q_data.first_byte && finished) |=> !finished || $stable(phase))
    else $error("finished parser changed section");

endmodule

[hdl/mesh_geometry_stream_parser_unit.sv]
// Path: an accepted byte passes the two-entry queue and the core, and its result
// is registered in the output register. Throughput: one byte per cycle unless a
// result is stalled at out_ready; the core stops and a full queue drops in_ready.
// Reset: synchronous rst clears the queue, the parser state and the output
// valid; magic_word returns to its reset value.
// ----------------------------------------------------------------------------
// mesh_geometry_stream_parser_unit
// Byte-stream parser for mesh geometry files with tagged field output.
// ----------------------------------------------------------------------------
module mesh_geometry_stream_parser_unit #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  mgsp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mgsp_pkg::out_word_t out_data
);

  logic               q_valid;
  logic               q_ready;
  mgsp_pkg::in_word_t q_data;
  logic [31:0]        magic_word;

  // hold expected magic word
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= mgsp_pkg::MAGIC_RESET;
    end else if (cfg_we) begin
      magic_word <= cfg_wdata;
    end
  end

  mgsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  mgsp_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .magic_word (magic_word),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
